// File: hw/rtl/cmf_pkg.sv
package cmf_pkg;

    typedef struct packed {
        logic [7:0] template_byte;
        logic [9:0] dest_col;
        logic [9:0] dest_line;
        logic       last;
    } cmf_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       end_of_string;
    } cmf_result_t;

    // one request from the decoder to the emitter: a literal byte, or a run of
    // decimal digits taken from a value below 1000
    typedef struct packed {
        logic       is_digits;
        logic [7:0] data;
        logic [9:0] value;
        logic [1:0] first_digit;
        logic [1:0] count;
        logic [1:0] status;
        logic       eos;
    } cmf_req_t;

    typedef enum logic [2:0] {
        PH_TEXT = 3'b001,
        PH_PCT  = 3'b010,
        PH_PLUS = 3'b100
    } cmf_phase_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic [1:0] DIG_HUND = 2'd0;
    localparam logic [1:0] DIG_TENS = 2'd1;
    localparam logic [1:0] DIG_ONES = 2'd2;

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_TWO  = 8'h32;
    localparam logic [7:0] CH_D    = 8'h64;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

endpackage

// File: hw/rtl/cmf_front.sv
module cmf_front
    import cmf_pkg::*;
#(
    parameter int OUT_LIMIT = 23
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  cmf_item_t item,
    input  logic      queue_full,
    output logic      push,
    output cmf_req_t  req
);

    localparam int SENT_W = $clog2(OUT_LIMIT + 1);

    cmf_phase_t        phase_reg, phase_next;
    logic              add_one_reg, add_one_next;
    logic              col_next_reg, col_next_next;
    logic [1:0]        err_reg, err_next;
    logic [SENT_W-1:0] sent_reg, sent_next;

    logic              accept;
    logic [10:0]       val_raw;
    logic [9:0]        val_mod;
    logic [1:0]        cnt;
    logic [1:0]        n_emit;
    logic [SENT_W-1:0] avail;

    assign accept     = item_valid && !queue_full;
    assign item_stall = queue_full;

    always_comb
    begin
        val_raw = {1'b0, (col_next_reg ? item.dest_col : item.dest_line)}
                  + {10'd0, add_one_reg};
        val_mod = (val_raw >= 11'd1000) ? 10'(val_raw - 11'd1000) : val_raw[9:0];
    end

    always_comb
    begin
        phase_next    = phase_reg;
        add_one_next  = add_one_reg;
        col_next_next = col_next_reg;
        err_next      = err_reg;
        cnt           = 2'd0;
        req.is_digits   = 1'b0;
        req.data        = item.template_byte;
        req.value       = val_mod;
        req.first_digit = DIG_ONES;

        if (err_reg != ST_BAD)
        begin
            unique case (phase_reg)
                PH_TEXT:
                begin
                    if (item.template_byte == CH_PCT)
                        phase_next = PH_PCT;
                    else
                        cnt = 2'd1;
                end
                PH_PCT:
                begin
                    phase_next = PH_TEXT;
                    unique case (item.template_byte)
                        CH_I:    add_one_next = 1'b1;
                        CH_R:    col_next_next = 1'b1;
                        CH_PLUS: phase_next = PH_PLUS;
                        CH_TWO:
                        begin
                            req.is_digits   = 1'b1;
                            req.first_digit = DIG_TENS;
                            cnt             = 2'd2;
                            col_next_next   = !col_next_reg;
                        end
                        CH_D:
                        begin
                            req.is_digits = 1'b1;
                            if (val_mod > 10'd99)
                            begin
                                req.first_digit = DIG_HUND;
                                cnt             = 2'd3;
                            end
                            else if (val_mod > 10'd9)
                            begin
                                req.first_digit = DIG_TENS;
                                cnt             = 2'd2;
                            end
                            else
                            begin
                                req.first_digit = DIG_ONES;
                                cnt             = 2'd1;
                            end
                            col_next_next = !col_next_reg;
                        end
                        CH_PCT:
                        begin
                            req.data = CH_PCT;
                            cnt      = 2'd1;
                        end
                        default: err_next = ST_BAD;
                    endcase
                end
                PH_PLUS:
                begin
                    phase_next    = PH_TEXT;
                    req.data      = val_raw[7:0] + item.template_byte;
                    cnt           = 2'd1;
                    col_next_next = !col_next_reg;
                end
                default: phase_next = PH_TEXT;
            endcase
        end

        // output limit: keep the leading bytes, drop the rest
        avail = (sent_reg >= SENT_W'(OUT_LIMIT)) ? '0 : SENT_W'(OUT_LIMIT) - sent_reg;
        if (SENT_W'(cnt) > avail)
        begin
            n_emit = avail[1:0];
            if (err_next == ST_OK)
                err_next = ST_OVF;
        end
        else
        begin
            n_emit = cnt;
        end
        sent_next = sent_reg + SENT_W'(n_emit);

        // directive cut off by the end of the template
        if (item.last && phase_next != PH_TEXT)
            err_next = ST_BAD;

        req.count  = n_emit;
        req.status = err_next;
        req.eos    = item.last;
    end

    assign push = accept && (n_emit != 2'd0 || item.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TEXT;
            add_one_reg  <= 1'b0;
            col_next_reg <= 1'b0;
            err_reg      <= ST_OK;
            sent_reg     <= '0;
        end
        else if (accept)
        begin
            if (item.last)
            begin
                phase_reg    <= PH_TEXT;
                add_one_reg  <= 1'b0;
                col_next_reg <= 1'b0;
                err_reg      <= ST_OK;
                sent_reg     <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                add_one_reg  <= add_one_next;
                col_next_reg <= col_next_next;
                err_reg      <= err_next;
                sent_reg     <= sent_next;
            end
        end
    end

    a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg <= SENT_W'(OUT_LIMIT))
        else $error("byte count beyond output limit");

    a_reset_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.last |=> sent_reg == '0 && phase_reg == PH_TEXT && err_reg == ST_OK)
        else $error("state not cleared after end of template");

    a_bad_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg == ST_BAD |-> !push || (req.count == 2'd0 && req.eos))
        else $error("bytes requested after a bad directive");

endmodule

// File: hw/rtl/cmf_queue.sv
module cmf_queue
    import cmf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cmf_req_t push_req,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output cmf_req_t head_req
);

    cmf_req_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign full       = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into full queue");

endmodule

// File: hw/rtl/cmf_back.sv
module cmf_back
    import cmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  cmf_req_t    head_req,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output cmf_result_t result
);

    logic        out_valid_reg;
    cmf_result_t out_reg;
    logic [1:0]  done_reg;

    logic        load;
    logic        last_byte;
    logic [1:0]  pos;
    logic [3:0]  hund, tens, ones;
    logic [6:0]  rem100;
    logic [3:0]  digit;

    // decimal digits of a value below 1000
    always_comb
    begin
        hund = '0;
        for (int k = 1; k <= 9; k++)
            if (head_req.value >= 10'(k * 100))
                hund = 4'(k);
        rem100 = 7'(head_req.value - {6'd0, hund} * 10'd100);
        tens = '0;
        for (int k = 1; k <= 9; k++)
            if (rem100 >= 7'(k * 10))
                tens = 4'(k);
        ones = 4'(rem100 - {3'd0, tens} * 7'd10);
    end

    always_comb
    begin
        pos = head_req.first_digit + done_reg;
        case (pos)
            DIG_HUND: digit = hund;
            DIG_TENS: digit = tens;
            default:  digit = ones;
        endcase
    end

    assign load      = head_valid && (!out_valid_reg || !result_stall);
    assign last_byte = (head_req.count == 2'd0) || (done_reg + 2'd1 == head_req.count);
    assign pop       = load && last_byte;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (head_req.count == 2'd0)
            begin
                out_reg.out_byte   <= 8'd0;
                out_reg.byte_valid <= 1'b0;
            end
            else
            begin
                out_reg.out_byte   <= head_req.is_digits ? CH_ZERO + {4'd0, digit}
                                                         : head_req.data;
                out_reg.byte_valid <= 1'b1;
            end
            out_reg.status        <= head_req.status;
            out_reg.end_of_string <= head_req.eos && last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            if (load)
                done_reg <= last_byte ? 2'd0 : done_reg + 2'd1;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.byte_valid |-> result.end_of_string)
        else $error("bare marker without end of string");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && head_req.count != 2'd0 |-> done_reg < head_req.count)
        else $error("digit counter past request length");

endmodule

// File: hw/rtl/cursor_motion_formatter_unit.sv
// Cursor motion formatter. Template bytes arrive one per request with the
// target column and line; the expanded escape sequence leaves one byte per
// result request, and the final result carries end_of_string and the status
// (0 ok, 1 bad directive, 2 output overflow; on status 1 the bytes already
// sent are to be discarded). The decoder takes one template byte every cycle
// while its four-entry request queue has room. The emitter drains the queue
// through a registered output at one byte per cycle unless result_stall is
// high, which sets the sustained rate; a plain byte gives one result byte,
// %2 two digits and %d one to three. There is no clearing pass after reset.
module cursor_motion_formatter_unit
    import cmf_pkg::*;
#(
    parameter int OUT_LIMIT = 23
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  cmf_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output cmf_result_t result
);

    logic     push, full, pop, head_valid;
    cmf_req_t req, head_req;

    cmf_front #(
        .OUT_LIMIT (OUT_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (full),
        .push       (push),
        .req        (req)
    );

    cmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_req   (req),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    cmf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_req     (head_req),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
